>>> rtl/tme_pkg.sv
// Package for the tape machine executor: opcodes, field widths, default depths
// and the control state type. No dependencies.
`timescale 1ns / 1ps

package tme_pkg;

    // default storage depths
    localparam int TME_TAPE_DEPTH = 65536;
    localparam int TME_PROG_DEPTH = 65536;

    // item field widths
    localparam int TME_ADDR_W = 16;
    localparam int TME_OP_W   = 3;
    localparam int TME_ARG_W  = 16;
    localparam int TME_BYTE_W = 8;
    localparam int TME_PC_W   = 17;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // opcodes
    localparam logic [TME_OP_W-1:0] OP_EMPTY = 3'd0;
    localparam logic [TME_OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [TME_OP_W-1:0] OP_WRITE = 3'd2;
    localparam logic [TME_OP_W-1:0] OP_LEFT  = 3'd3;
    localparam logic [TME_OP_W-1:0] OP_RIGHT = 3'd4;
    localparam logic [TME_OP_W-1:0] OP_IFEQ  = 3'd5;
    localparam logic [TME_OP_W-1:0] OP_GOTO  = 3'd6;

    // value of tape cell 0 after reset
    localparam logic [TME_BYTE_W-1:0] TME_CELL0_INIT = 8'hFF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

>>> rtl/tape_machine_executor.sv
// Tape machine executor: each item is accepted in the idle state, while the program and
// tape RAMs are read at the program counter and head, then executed in the exec state on
// the registered read data, loading the result register. No new item is accepted until
// the current one commits, which waits while a stalled result is not taken. After reset a
// clearing pass zeroes both RAMs (tape cell 0 set to 255) with ready held low. Reset is
// synchronous, active low. Depends on tme_pkg and tme_ram.
`timescale 1ns / 1ps

module tape_machine_executor
    import tme_pkg::*;
#(
    parameter int TAPE_DEPTH = TME_TAPE_DEPTH,
    parameter int PROG_DEPTH = TME_PROG_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [TME_ADDR_W-1:0] i_slot_addr,
    input  logic [TME_OP_W-1:0]   i_slot_op,
    input  logic [TME_ARG_W-1:0]  i_slot_arg,
    input  logic [TME_BYTE_W-1:0] i_in_byte,
    // result channel
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic                  o_out_valid,
    output logic [TME_BYTE_W-1:0] o_out_byte,
    output logic                  o_took_input,
    output logic                  o_halted,
    output logic                  o_head_fault
);

    // address widths of the two memories and of the clearing sweep
    localparam int PAW   = $clog2(PROG_DEPTH);
    localparam int TAW   = $clog2(TAPE_DEPTH);
    localparam int MAXD  = (PROG_DEPTH > TAPE_DEPTH) ? PROG_DEPTH : TAPE_DEPTH;
    localparam int CW    = $clog2(MAXD);
    localparam int PW    = TME_OP_W + TME_ARG_W;

    localparam logic [TME_PC_W-1:0] PC_LIMIT  = TME_PC_W'(PROG_DEPTH);
    localparam logic [CW:0]         CLR_PROG  = (CW + 1)'(PROG_DEPTH);
    localparam logic [CW:0]         CLR_TAPE  = (CW + 1)'(TAPE_DEPTH);
    localparam logic [CW-1:0]       CLR_LAST  = CW'(MAXD - 1);
    localparam logic [TAW-1:0]      HEAD_LAST = TAW'(TAPE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic [CW-1:0] r_clr;

    // machine registers
    logic [TME_PC_W-1:0]   r_pc, n_pc;
    logic [TAW-1:0]        r_head, n_head;
    logic                  r_skip, n_skip;
    logic [TME_ADDR_W-1:0] r_top, n_top;

    // the item being executed, held from the accepting edge
    logic                  r_cmd;
    logic [TME_ADDR_W-1:0] r_addr;
    logic [TME_OP_W-1:0]   r_op;
    logic [TME_ARG_W-1:0]  r_arg;
    logic [TME_BYTE_W-1:0] r_byte;

    // result register
    logic                  r_res_valid;
    logic                  r_out_valid, n_out_valid;
    logic [TME_BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                  r_took, n_took;
    logic                  r_halted, n_halted;
    logic                  r_fault, n_fault;

    logic accept, clearing, executing, fire, clr_done;
    logic step_prog_we, step_tape_we, run, skip_now;

    // memory ports
    logic           prog_we, tape_we;
    logic [PAW-1:0] prog_waddr;
    logic [TAW-1:0] tape_waddr;
    logic [PW-1:0]  prog_wdata, prog_rdata;
    logic [TME_BYTE_W-1:0] tape_wdata, tape_rdata;
    logic [TME_OP_W-1:0]   cur_op;
    logic [TME_ARG_W-1:0]  cur_arg;

    assign accept   = i_valid && o_ready;
    assign clr_done = (r_clr == CLR_LAST);

    // ------------------------------------------------------------------
    // State machine: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State machine: outputs. Execution commits only once the result register
    // has room, so a stalled result holds the machine in place.
    always_comb begin
        o_ready   = 1'b0;
        clearing  = 1'b0;
        executing = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing  = 1'b1;
            ST_IDLE:  o_ready   = 1'b1;
            ST_EXEC:  executing = 1'b1;
            default:  clearing  = 1'b1;
        endcase
        fire = executing && (!r_res_valid || i_res_ready);
    end

    // ------------------------------------------------------------------
    // Memories: the program RAM holds {op, arg} per slot. Read addresses
    // follow the program counter and head, which stay put between the
    // accepting edge and the commit, so the read data is stable while a
    // result stalls.
    // ------------------------------------------------------------------
    always_comb begin
        if (clearing) begin
            prog_we    = ({1'b0, r_clr} < CLR_PROG);
            prog_waddr = r_clr[PAW-1:0];
            prog_wdata = '0;
            tape_we    = ({1'b0, r_clr} < CLR_TAPE);
            tape_waddr = r_clr[TAW-1:0];
            tape_wdata = (r_clr == '0) ? TME_CELL0_INIT : '0;
        end else begin
            prog_we    = fire && step_prog_we;
            prog_waddr = r_addr[PAW-1:0];
            prog_wdata = {r_op, r_arg};
            tape_we    = fire && step_tape_we;
            tape_waddr = r_head;
            tape_wdata = r_byte;
        end
    end

    tme_ram #(
        .WIDTH (PW),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (prog_wdata),
        .i_raddr (r_pc[PAW-1:0]),
        .o_rdata (prog_rdata)
    );

    tme_ram #(
        .WIDTH (TME_BYTE_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (r_head),
        .o_rdata (tape_rdata)
    );

    assign cur_op  = prog_rdata[PW-1:TME_ARG_W];
    assign cur_arg = prog_rdata[TME_ARG_W-1:0];

    // ------------------------------------------------------------------
    // Execute: work out the item's effect from the registered read data
    // ------------------------------------------------------------------
    assign run      = (r_pc <= {1'b0, r_top}) && (r_pc < PC_LIMIT);
    assign skip_now = (cur_op != OP_EMPTY) && r_skip;

    always_comb begin
        n_pc         = r_pc;
        n_head       = r_head;
        n_skip       = r_skip;
        n_top        = r_top;
        step_prog_we = 1'b0;
        step_tape_we = 1'b0;
        n_out_valid  = 1'b0;
        n_out_byte   = '0;
        n_took       = 1'b0;
        n_fault      = 1'b0;
        if (r_cmd == CMD_LOAD) begin
            // drop loads beyond program memory
            if ({1'b0, r_addr} < PC_LIMIT) begin
                step_prog_we = 1'b1;
                if (r_addr > r_top) begin
                    n_top = r_addr;
                end
            end
        end else if (run) begin
            n_pc = r_pc + TME_PC_W'(1);
            if (skip_now) begin
                // pass over this slot and disarm the skip
                n_skip = 1'b0;
            end else begin
                unique case (cur_op)
                    OP_READ: begin
                        step_tape_we = 1'b1;
                        n_took       = 1'b1;
                    end
                    OP_WRITE: begin
                        n_out_valid = 1'b1;
                        n_out_byte  = tape_rdata;
                    end
                    OP_LEFT: begin
                        if (r_head == '0) begin
                            n_fault = 1'b1;
                        end else begin
                            n_head = r_head - TAW'(1);
                        end
                    end
                    OP_RIGHT: begin
                        if (r_head >= HEAD_LAST) begin
                            n_fault = 1'b1;
                        end else begin
                            n_head = r_head + TAW'(1);
                        end
                    end
                    OP_IFEQ: begin
                        if ({{(TME_ARG_W - TME_BYTE_W){1'b0}}, tape_rdata} != cur_arg) begin
                            n_skip = 1'b1;
                        end
                    end
                    OP_GOTO: begin
                        n_pc = {1'b0, cur_arg};
                    end
                    default: begin
                        // empty slot or unused opcode: no effect
                    end
                endcase
            end
        end
        n_halted = (n_pc > {1'b0, n_top});
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pc        <= TME_PC_W'(1);
            r_head      <= TAW'(1);
            r_skip      <= 1'b0;
            r_top       <= TME_ADDR_W'(1);
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the clearing sweep
            if (clearing) begin
                r_clr <= r_clr + CW'(1);
            end
            // commit the machine state together with the result
            if (fire) begin
                r_pc   <= n_pc;
                r_head <= n_head;
                r_skip <= n_skip;
                r_top  <= n_top;
            end
            if (fire) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // item and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_addr <= i_slot_addr;
            r_op   <= i_slot_op;
            r_arg  <= i_slot_arg;
            r_byte <= i_in_byte;
        end
        if (fire) begin
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_took      <= n_took;
            r_halted    <= n_halted;
            r_fault     <= n_fault;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_took_input = r_took;
    assign o_halted     = r_halted;
    assign o_head_fault = r_fault;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted item did not enter execution");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_res_valid)
        else $error("executed item produced no result");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (executing && !fire) |=> ($stable(r_pc) && $stable(r_head) && $stable(r_skip)))
        else $error("machine state moved while the result stalled");

    a_halted_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (o_halted == (r_pc > {1'b0, r_top})))
        else $error("halted flag disagrees with program counter");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= HEAD_LAST)
        else $error("head left the tape");

endmodule

>>> rtl/tme_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
